### rtl/core/salc_pkg.sv
// Package for the set-associative LRU cache tag block.
// Holds the operation codes, register indexes and the configuration and
// result structures. Depends on nothing.
`default_nettype none

package salc_pkg;

    // Operation carried with each address.
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS  = 2'd2;

    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int RESULT_W   = 100;
    localparam int OUT_PAD_W  = 4;
    localparam int OUT_DATA_W = RESULT_W + OUT_PAD_W;

    typedef struct packed {
        logic [3:0] block_bits;
        logic [3:0] ways_in_use;
        logic [2:0] set_bits;
    } cfg_t;

    // Last field sits in the lowest bits.
    typedef struct packed {
        logic [31:0] total_evictions;
        logic [31:0] total_misses;
        logic [31:0] total_hits;
        logic        evicted;
        logic        missed;
        logic [1:0]  hit_count;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/salc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-set line storage. Depends on nothing.
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/salc_queue.sv
// Small FIFO that decouples the classifying front end from the back end.
// Register based, parameterized in width and depth. Depends on nothing.
`default_nettype none

module salc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/salc_front.sv
// Front end: accepts input transactions and splits each address into set
// index and tag with the configured bit counts. Depends on salc_pkg.
`default_nettype none

module salc_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire salc_pkg::cfg_t                        cfg,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [salc_pkg::IN_USER_W-1:0]        in_mode,
    input  wire logic [salc_pkg::IN_DATA_W-1:0]        in_addr,
    input  wire logic                                  accept_en,
    output logic                                       push,
    output salc_pkg::mode_t                            acc_mode,
    output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] acc_set,
    output logic [ADDR_WIDTH-1:0]                      acc_tag
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [3:0]            set_eff;
    logic [ADDR_WIDTH-1:0] addr_w;
    logic [ADDR_WIDTH-1:0] shifted;

    assign in_ready = accept_en;
    assign push     = in_valid && accept_en;

    always_comb begin
        // Set bit counts beyond the built-in maximum saturate.
        set_eff  = (32'(cfg.set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS)
                                                        : 4'(cfg.set_bits);
        addr_w   = ADDR_WIDTH'(in_addr);
        shifted  = addr_w >> cfg.block_bits;
        // With no set bits the mask stays all ones, so its inverse is zero and the index is 0.
        acc_set  = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << set_eff);
        acc_tag  = addr_w >> (5'(set_eff) + 5'(cfg.block_bits));
        acc_mode = salc_pkg::mode_t'(in_mode);
    end

endmodule

`default_nettype wire

### rtl/core/salc_back.sv
// Back end: reads one set row, compares tags, picks the victim, updates the
// LRU ranks and totals, and holds the result register. Depends on salc_pkg
// and salc_ram.
`default_nettype none

module salc_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [3:0]      ways_in_use,
    input  wire logic            q_valid,
    input  wire logic [2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH - 1:0] q_data,
    output logic                 q_pop,
    output logic                 init_done,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output salc_pkg::result_t    res
);

    localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W     = RANK_W;
    localparam int CNT_W     = $clog2(MAX_WAYS + 1);
    localparam int RANK_BASE = MAX_WAYS;
    localparam int TAG_BASE  = MAX_WAYS * (1 + RANK_W);
    localparam int ROW_W     = MAX_WAYS * (1 + RANK_W + ADDR_WIDTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t                state_reg, state_next;
    logic [SET_W-1:0]      clr_idx_reg, clr_idx_next;
    salc_pkg::mode_t       mode_reg, mode_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [ADDR_WIDTH-1:0] tag_reg, tag_next;
    logic                  res_valid_reg, res_valid_next;
    salc_pkg::result_t     res_reg, res_next;
    logic [31:0]           hit_total_reg, hit_total_next;
    logic [31:0]           miss_total_reg, miss_total_next;
    logic [31:0]           evict_total_reg, evict_total_next;

    logic                  ram_we, ram_re;
    logic [SET_W-1:0]      ram_waddr, ram_raddr;
    logic [ROW_W-1:0]      ram_wdata, ram_rdata;

    logic [MAX_WAYS-1:0]   row_valid, in_use, hit_vec, inv_vec;
    logic [RANK_W-1:0]     row_rank [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] row_tag  [MAX_WAYS];
    logic [CNT_W-1:0]      ways_eff;
    logic                  hit, found, is_access, missed, evicted;
    logic [WAY_W-1:0]      hit_way, inv_way, lru_way, pick_way;
    logic [RANK_W-1:0]     lru_rank_v, pick_rank;
    logic [ROW_W-1:0]      eval_row, clear_row;
    logic [1:0]            hit_cnt;
    logic [32:0]           hit_sum;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Way count: zero acts as one, values above the maximum saturate.
    always_comb begin
        if (ways_in_use == 4'd0) begin
            ways_eff = CNT_W'(1);
        end else if (32'(ways_in_use) > MAX_WAYS) begin
            ways_eff = CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = CNT_W'(ways_in_use);
        end
    end

    // Tag compare, victim choice and the updated row.
    always_comb begin
        clear_row = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row_valid[w] = ram_rdata[w];
            row_rank[w]  = ram_rdata[RANK_BASE + w * RANK_W +: RANK_W];
            row_tag[w]   = ram_rdata[TAG_BASE + w * ADDR_WIDTH +: ADDR_WIDTH];
            in_use[w]    = CNT_W'(w) < ways_eff;
            hit_vec[w]   = in_use[w] && row_valid[w] && (row_tag[w] == tag_reg);
            inv_vec[w]   = in_use[w] && !row_valid[w];
            clear_row[RANK_BASE + w * RANK_W +: RANK_W] = RANK_W'(w);
        end

        hit     = |hit_vec;
        found   = |inv_vec;
        hit_way = '0;
        inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (inv_vec[w]) begin
                inv_way = WAY_W'(w);
            end
        end

        // Oldest way in use; ranks are a permutation, so no ties.
        lru_way    = '0;
        lru_rank_v = row_rank[0];
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (row_rank[w] > lru_rank_v)) begin
                lru_way    = WAY_W'(w);
                lru_rank_v = row_rank[w];
            end
        end

        if (hit) begin
            pick_way = hit_way;
        end else if (found) begin
            pick_way = inv_way;
        end else begin
            pick_way = lru_way;
        end
        pick_rank = row_rank[pick_way];

        eval_row = ram_rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == pick_way) begin
                eval_row[w] = 1'b1;
                eval_row[RANK_BASE + w * RANK_W +: RANK_W]       = '0;
                eval_row[TAG_BASE + w * ADDR_WIDTH +: ADDR_WIDTH] = tag_reg;
            end else if (row_rank[w] < pick_rank) begin
                eval_row[RANK_BASE + w * RANK_W +: RANK_W] = row_rank[w] + 1'b1;
            end
        end

        // The second access of a modify always hits the line just touched,
        // which is already most recent, so it only adds a hit.
        is_access = (mode_reg != salc_pkg::MODE_NONE);
        missed    = is_access && !hit;
        evicted   = missed && !found;
        hit_cnt   = {1'b0, is_access && hit} + {1'b0, mode_reg == salc_pkg::MODE_MODIFY};
        hit_sum   = 33'(hit_total_reg) + 33'(hit_cnt);
    end

    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        mode_next        = mode_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg;
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        evict_total_next = evict_total_reg;
        ram_we           = 1'b0;
        ram_waddr        = set_reg;
        ram_wdata        = eval_row;
        ram_re           = 1'b0;
        ram_raddr        = q_data[2 +: SET_W];
        q_pop            = 1'b0;

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = clear_row;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    mode_next  = salc_pkg::mode_t'(q_data[1:0]);
                    set_next   = q_data[2 +: SET_W];
                    tag_next   = q_data[2 + SET_W +: ADDR_WIDTH];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!res_valid_reg || res_ready) begin
                    ram_we = is_access;
                    hit_total_next = hit_sum[32] ? '1 : hit_sum[31:0];
                    if (missed && (miss_total_reg != '1)) begin
                        miss_total_next = miss_total_reg + 1'b1;
                    end
                    if (evicted && (evict_total_reg != '1)) begin
                        evict_total_next = evict_total_reg + 1'b1;
                    end
                    res_next.hit_count       = hit_cnt;
                    res_next.missed          = missed;
                    res_next.evicted         = evicted;
                    res_next.total_hits      = hit_total_next;
                    res_next.total_misses    = miss_total_next;
                    res_next.total_evictions = evict_total_next;
                    res_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            res_valid_reg   <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            res_valid_reg   <= res_valid_next;
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
        mode_reg <= mode_next;
        set_reg  <= set_next;
        tag_reg  <= tag_next;
        res_reg  <= res_next;
    end

    assign init_done = (state_reg != ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/core/set_assoc_lru_cache_tags.sv
// Tag and true-LRU replacement logic of a set-associative cache. Each input
// transaction carries an operation (load, store, modify or none) and a byte
// address; each one returns exactly one result transaction with its own hit,
// miss and eviction flags and the saturating running totals. Right after
// reset the block runs a clearing pass over all 2**MAX_SET_BITS rows of its
// set memory; s_axis_tready stays low during that pass, while configuration
// writes are taken as usual. After that the back end reads an item's set
// row from the line memory, then compares all ways and writes the row back,
// waiting there while an earlier result is still held. A modify takes the
// same read and write-back because its second access always hits the line
// the first one touched. The read-then-write of the one set memory means the
// back end writes one item's row back before it reads the next.
//
// Depends on salc_pkg, salc_front, salc_queue, salc_back and salc_ram.
`default_nettype none

module set_assoc_lru_cache_tags #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [salc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [salc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [salc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,

    // Input transactions.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [salc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [31:0] address
    input  wire logic [salc_pkg::IN_USER_W-1:0]      s_axis_tuser,  // [1:0] mode

    // Result transactions.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] hit_count, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic      [salc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENTRY_W    = 2 + SET_W + ADDR_WIDTH;
    localparam int QUEUE_DEPTH = 2;

    // Configuration registers. Writes land on the access cycle of a write;
    // paddr[3:2] selects the register.
    salc_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (paddr[3:2])
                salc_pkg::REG_SET_BITS:    cfg_next.set_bits    = pwdata[2:0];
                salc_pkg::REG_WAYS_IN_USE: cfg_next.ways_in_use = pwdata[3:0];
                salc_pkg::REG_BLOCK_BITS:  cfg_next.block_bits  = pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_bits    <= 3'd0;
            cfg_reg.ways_in_use <= 4'd1;
            cfg_reg.block_bits  <= 4'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            salc_pkg::REG_SET_BITS:    prdata = 32'(cfg_reg.set_bits);
            salc_pkg::REG_WAYS_IN_USE: prdata = 32'(cfg_reg.ways_in_use);
            salc_pkg::REG_BLOCK_BITS:  prdata = 32'(cfg_reg.block_bits);
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Front end: accept and split the address.
    logic                  init_done;
    logic                  q_full, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0]    q_head;
    salc_pkg::mode_t       acc_mode;
    logic [SET_W-1:0]      acc_set;
    logic [ADDR_WIDTH-1:0] acc_tag;

    salc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_addr   (s_axis_tdata),
        .accept_en (init_done && !q_full),
        .push      (q_push),
        .acc_mode  (acc_mode),
        .acc_set   (acc_set),
        .acc_tag   (acc_tag)
    );

    // Short queue of classified accesses, mode in the lowest bits.
    salc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (aclk),
        .rst_n      (aresetn),
        .push       (q_push),
        .push_data  ({acc_tag, acc_set, acc_mode}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Back end: lookup, replacement and the result register.
    salc_pkg::result_t res;

    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_back (
        .clk         (aclk),
        .rst_n       (aresetn),
        .ways_in_use (cfg_reg.ways_in_use),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .init_done   (init_done),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {{salc_pkg::OUT_PAD_W{1'b0}}, res};

endmodule

`default_nettype wire

### rtl/core/salc_checker.sv
// Port-level checker for the cache tag block, bound to the top level.
// Depends on salc_pkg and the top level's port names.
`default_nettype none

module salc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [salc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset starts the clearing pass: no input taken, no result shown.
    assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block active right after reset");

    // Per-item flags agree: at most two hits, an eviction implies a miss,
    // and two hits rule out a miss.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)
                          && (!m_axis_tdata[3] || m_axis_tdata[2])
                          && !(m_axis_tdata[2] && (m_axis_tdata[1:0] == 2'd2)))
        else $error("inconsistent per-item result flags");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);

`default_nettype wire

### dv/set_assoc_lru_cache_tags_test.sv
// Self-checking testbench for set_assoc_lru_cache_tags: stream traffic in,
// results checked against a cycle-free tracker of tags, LRU ranks and totals.
// Depends on salc_pkg and the RTL of the block; nothing else.
`default_nettype none

module set_assoc_lru_cache_tags_test;

    localparam int SET_LIMIT       = 6;    // MAX_SET_BITS of the block
    localparam int WAY_LIMIT       = 8;    // MAX_WAYS of the block
    localparam int LINES           = (1 << SET_LIMIT) * WAY_LIMIT;
    localparam int IDLE_LIMIT      = 2000; // cycles without any transaction
    localparam int RANDOM_PHASES   = 24;
    localparam int ITEMS_PER_PHASE = 45;

    // Tracks the cache contents and the running totals, and keeps the results
    // that accepted transactions are due to produce, oldest first.
    class lru_cache_tracker;
        bit                valid[LINES];
        logic [31:0]       tags[LINES];
        bit   [2:0]        rank[LINES];
        bit   [31:0]       hit_total, miss_total, evict_total;
        bit   [2:0]        set_bits;
        bit   [3:0]        ways;
        bit   [3:0]        block_bits;
        salc_pkg::result_t pending_results[$];
        int                mode_count[4];
        int                checked, mismatches;

        function new();
            for (int i = 0; i < LINES; i++) begin
                valid[i] = 1'b0;
                rank[i]  = 3'(i % WAY_LIMIT);
            end
            hit_total   = '0;
            miss_total  = '0;
            evict_total = '0;
            set_bits    = 3'd0;
            ways        = 4'd1;
            block_bits  = 4'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                salc_pkg::REG_SET_BITS:    set_bits   = value[2:0];
                salc_pkg::REG_WAYS_IN_USE: ways       = value[3:0];
                salc_pkg::REG_BLOCK_BITS:  block_bits = value[3:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] bump(bit [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        // Make one way the most recent; every way younger than it ages by one.
        function void promote(int base, int way);
            bit [2:0] r;
            r = rank[base + way];
            for (int w = 0; w < WAY_LIMIT; w++) begin
                if (rank[base + w] < r) rank[base + w]++;
            end
            rank[base + way] = 3'd0;
        endfunction

        // One access; returns 1 on a hit and sets replaced on an eviction.
        function bit lookup_and_fill(logic [31:0] addr, inout bit replaced);
            int          s, e, set_idx, base, pick;
            logic [31:0] tag;
            bit          found;
            s = (set_bits > SET_LIMIT) ? SET_LIMIT : int'(set_bits);
            e = (ways == 0) ? 1 : ((ways > WAY_LIMIT) ? WAY_LIMIT : int'(ways));
            set_idx = int'((addr >> block_bits) & ((32'd1 << s) - 32'd1));
            tag  = addr >> (s + block_bits);
            base = set_idx * WAY_LIMIT;
            for (int w = 0; w < e; w++) begin
                if (valid[base + w] && tags[base + w] == tag) begin
                    hit_total = bump(hit_total);
                    promote(base, w);
                    return 1'b1;
                end
            end
            miss_total = bump(miss_total);
            pick  = 0;
            found = 1'b0;
            for (int w = 0; w < e && !found; w++) begin
                if (!valid[base + w]) begin
                    pick  = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                evict_total = bump(evict_total);
                replaced    = 1'b1;
                for (int w = 1; w < e; w++) begin
                    if (rank[base + w] > rank[base + pick]) pick = w;
                end
            end
            valid[base + pick] = 1'b1;
            tags[base + pick]  = tag;
            promote(base, pick);
            return 1'b0;
        endfunction

        function void note_access(salc_pkg::mode_t mode, logic [31:0] addr);
            salc_pkg::result_t r;
            bit                replaced, miss;
            bit [1:0]          hits;
            replaced = 1'b0;
            miss     = 1'b0;
            hits     = 2'd0;
            mode_count[int'(mode)]++;
            if (mode != salc_pkg::MODE_NONE) begin
                if (lookup_and_fill(addr, replaced)) hits++;
                else miss = 1'b1;
                if (mode == salc_pkg::MODE_MODIFY && lookup_and_fill(addr, replaced)) hits++;
            end
            r.hit_count       = hits;
            r.missed          = miss;
            r.evicted         = replaced;
            r.total_hits      = hit_total;
            r.total_misses    = miss_total;
            r.total_evictions = evict_total;
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void flag(string field, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d field %s expected 0x%0h got 0x%0h",
                         checked, field, want, got);
        endfunction

        function void check_result(salc_pkg::result_t got);
            salc_pkg::result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result transaction with nothing pending: 0x%0h", got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.hit_count !== want.hit_count)
                flag("hit_count", want.hit_count, got.hit_count);
            if (got.missed !== want.missed)
                flag("missed", want.missed, got.missed);
            if (got.evicted !== want.evicted)
                flag("evicted", want.evicted, got.evicted);
            if (got.total_hits !== want.total_hits)
                flag("total_hits", want.total_hits, got.total_hits);
            if (got.total_misses !== want.total_misses)
                flag("total_misses", want.total_misses, got.total_misses);
            if (got.total_evictions !== want.total_evictions)
                flag("total_evictions", want.total_evictions, got.total_evictions);
        endfunction
    endclass

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [salc_pkg::CFG_ADDR_W-1:0] paddr         = '0;
    logic [salc_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [salc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [salc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] address
    logic [salc_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;  // [1:0] mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [1:0] hit_count, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    logic [salc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // A quiet phase runs with neither side idling, so that the block sees
    // back-to-back transactions on both channels.
    bit quiet_phase = 1'b0;
    int settings_used = 0;

    lru_cache_tracker tracker = new();

    set_assoc_lru_cache_tags DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle lengths: mostly a few cycles, now and then a long stretch.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // All tasks are entered right after a rising edge and sample the block's
    // outputs there, so they see the values that held at that edge.

    // APB write: setup cycle, access cycle, then a wait with psel low so that
    // back-to-back writes never assign psel twice in one time step.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int sbits, input int nways, input int bbits);
        write_reg(salc_pkg::REG_SET_BITS, 32'(sbits));
        write_reg(salc_pkg::REG_WAYS_IN_USE, 32'(nways));
        write_reg(salc_pkg::REG_BLOCK_BITS, 32'(bbits));
        settings_used++;
    endtask

    // Hold the input side until every pending result has come back, then let
    // a few more cycles pass so the back end is surely empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Offer one transaction, optionally after a gap, and wait for acceptance.
    // tvalid stays high across back-to-back transactions.
    task automatic send_item(input salc_pkg::mode_t mode, input logic [31:0] addr);
        int gap;
        gap = (quiet_phase || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= addr;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_access(mode, addr);
    endtask

    // Result side: checks every accepted result and stalls at random, with
    // short stalls mostly and an occasional long one.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(
                    salc_pkg::result_t'(m_axis_tdata[salc_pkg::RESULT_W-1:0]));
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                stall_left = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any transaction on either channel or the configuration port
    // restarts the count. The clearing pass after reset is far below it.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ERROR: no transaction for %0d cycles, %0d results pending",
                 IDLE_LIMIT, tracker.pending());
        $display("FAIL set_assoc_lru_cache_tags");
        $finish;
    end

    initial begin
        int          sbits, nways, bbits, pool_n;
        logic [31:0] mask, addr;
        logic [31:0] pool[$];

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers may be written during the clearing pass; start from the
        // reset setting: one set, one way, no offset.
        configure(0, 1, 0);
        send_item(salc_pkg::MODE_LOAD, 32'h0000_0000);    // cold miss
        send_item(salc_pkg::MODE_LOAD, 32'h0000_0000);    // hit
        send_item(salc_pkg::MODE_STORE, 32'hFFFF_FFFF);   // miss that evicts the only way
        send_item(salc_pkg::MODE_MODIFY, 32'hFFFF_FFFF);  // two hits
        send_item(salc_pkg::MODE_MODIFY, 32'h1234_5678);  // miss and evict, then a hit
        send_item(salc_pkg::MODE_NONE, 32'hA5A5_A5A5);    // no access, totals unchanged
        send_item(salc_pkg::MODE_LOAD, 32'h0000_0000);

        // Register values beyond the limits: set bits saturate to six, the
        // way count to eight, and the widest block offset is used as given.
        // Contents survive the change, so address zero hits again.
        drain();
        configure(7, 15, 15);
        send_item(salc_pkg::MODE_LOAD, 32'h0000_0000);
        // Fill all eight ways of set zero, then push out the oldest line.
        for (int k = 1; k <= 8; k++) send_item(salc_pkg::MODE_LOAD, 32'(k) << 21);
        send_item(salc_pkg::MODE_LOAD, 32'h0000_7FFF);
        send_item(salc_pkg::MODE_STORE, 32'hFFFF_FFFF);

        // A way count of zero behaves as a single way.
        drain();
        configure(0, 0, 0);
        send_item(salc_pkg::MODE_LOAD, 32'h0000_0005);
        send_item(salc_pkg::MODE_MODIFY, 32'h0000_0005);
        send_item(salc_pkg::MODE_NONE, 32'h0000_0000);

        // Random phases: each uses a fresh register setting and a small pool
        // of base addresses, so lines get reused, hit and evicted. A tenth of
        // the traffic is fully random addresses as noise.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p)
                0: begin sbits = 6; nways = 8;  bbits = 12; end
                1: begin sbits = 0; nways = 8;  bbits = 0;  end
                2: begin sbits = 7; nways = 1;  bbits = 15; end
                3: begin sbits = 2; nways = 2;  bbits = 4;  end
                default: begin
                    sbits = $urandom_range(0, 7);
                    nways = $urandom_range(0, 15);
                    bbits = $urandom_range(0, 15);
                end
            endcase
            configure(sbits, nways, bbits);
            quiet_phase <= (p % 6 == 4);
            pool_n = $urandom_range(1, 24);
            pool.delete();
            repeat (pool_n) pool.push_back($urandom);
            mask = (32'd1 << bbits) - 32'd1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Now and then, and once for sure, let the pipeline run empty
                // in the middle of a phase.
                if ((p == 1 && i == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
                    drain();
                if ($urandom_range(0, 9) == 0)
                    addr = $urandom;
                else
                    addr = pool[$urandom_range(0, pool_n - 1)] ^ ($urandom & mask);
                send_item(salc_pkg::mode_t'($urandom_range(0, 3)), addr);
            end
        end

        drain();
        repeat (12) @(posedge aclk);

        $display("Covered %0d load, %0d store, %0d modify, %0d none over %0d settings.",
                 tracker.mode_count[int'(salc_pkg::MODE_LOAD)],
                 tracker.mode_count[int'(salc_pkg::MODE_STORE)],
                 tracker.mode_count[int'(salc_pkg::MODE_MODIFY)],
                 tracker.mode_count[int'(salc_pkg::MODE_NONE)], settings_used);
        $display("Saw %0d hits, %0d misses, %0d evictions; %0d results compared, %0d mismatches.",
                 tracker.hit_total, tracker.miss_total, tracker.evict_total,
                 tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("PASS set_assoc_lru_cache_tags");
        end else begin
            $display("FAIL set_assoc_lru_cache_tags");
        end
        $finish;
    end

endmodule

`default_nettype wire

### set_assoc_lru_cache_tags.f
rtl/core/salc_pkg.sv
rtl/core/salc_ram.sv
rtl/core/salc_queue.sv
rtl/core/salc_front.sv
rtl/core/salc_back.sv
rtl/core/set_assoc_lru_cache_tags.sv
rtl/core/salc_checker.sv
dv/set_assoc_lru_cache_tags_test.sv
